FILE: rtl/rcpw_pkg.sv
// Shared types, constants and register codes for the RC pulse width capture block.
`timescale 1ns / 1ps
package rcpw_pkg;

	localparam int NUM_WIDTHS   = 4;
	localparam int CHANNELS_DEF = 4;
	localparam int WIDTH_W      = 16;
	localparam int STAMP_W      = 32;
	localparam int MASK_W       = 4;
	localparam int CFG_INDEX_W  = 8;
	localparam int CFG_DATA_W   = 16;
	localparam int IN_TDATA_W   = 40;
	localparam int OUT_PAYLOAD_W = NUM_WIDTHS * WIDTH_W + MASK_W;
	localparam int OUT_TDATA_W  = ((OUT_PAYLOAD_W + 7) / 8) * 8;

	localparam logic [WIDTH_W-1:0] MIN_HIGH_RST = 16'd950;
	localparam logic [WIDTH_W-1:0] MAX_HIGH_RST = 16'd2075;
	localparam logic [WIDTH_W-1:0] MIN_GAP_RST  = 16'd12000;
	localparam logic [WIDTH_W-1:0] MAX_GAP_RST  = 16'd24000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MIN_HIGH = 8'd0,
		REG_MAX_HIGH = 8'd1,
		REG_MIN_GAP  = 8'd2,
		REG_MAX_GAP  = 8'd3
	} rcpw_reg_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] min_high;
		logic [WIDTH_W-1:0] max_high;
		logic [WIDTH_W-1:0] min_gap;
		logic [WIDTH_W-1:0] max_gap;
	} rcpw_cfg_t;

	typedef struct packed {
		logic               upd;
		logic [WIDTH_W-1:0] width;
	} rcpw_lane_out_t;

endpackage

FILE: rtl/rc_pulse_width_capture.sv
// Top level of the RC pulse width capture block: config registers, channel lanes, merge.
//
//   channel  handshake            payload (lowest bit up)
//   s_       s_tvalid/s_tready    edge_mask[3:0], pin_levels[7:4], now_us[39:8]
//   m_       m_tvalid/m_tready    widths roll..throttle 16b each, updated_mask, pad
//   cfg_     cfg_valid/cfg_ready  cfg_index (register 0..3), cfg_data 16b
//
// One item per cycle while s_tready is high; results are registered before they reach m_.
// Each lane forms gap and high time with two subtracts and window compares per item.
// Reset clears all lane state and loads the default windows.
// A stalled result holds in the output register; one more item goes to the
// skid stage, after which s_tready drops until the held result is taken.
`timescale 1ns / 1ps
module rc_pulse_width_capture #(
	parameter int CHANNELS = rcpw_pkg::CHANNELS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [rcpw_pkg::IN_TDATA_W-1:0]    s_tdata,  // edge_mask, pin_levels, now_us
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [rcpw_pkg::OUT_TDATA_W-1:0]   m_tdata,  // width_roll, width_pitch, width_yaw,
	                                                     // width_throttle, updated_mask, pad
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rcpw_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rcpw_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rcpw_pkg::*;

	localparam int LANES = (CHANNELS < NUM_WIDTHS) ? CHANNELS : NUM_WIDTHS;

	rcpw_cfg_t                          cfg_q;
	rcpw_lane_out_t [NUM_WIDTHS-1:0]    lanes;
	logic                               accept;
	logic [MASK_W-1:0]                  edge_mask;
	logic [MASK_W-1:0]                  pin_levels;
	logic [STAMP_W-1:0]                 now_us;

	assign edge_mask  = s_tdata[MASK_W-1:0];
	assign pin_levels = s_tdata[2*MASK_W-1:MASK_W];
	assign now_us     = s_tdata[2*MASK_W+STAMP_W-1:2*MASK_W];
	assign accept     = s_tvalid && s_tready;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_high <= MIN_HIGH_RST;
			cfg_q.max_high <= MAX_HIGH_RST;
			cfg_q.min_gap  <= MIN_GAP_RST;
			cfg_q.max_gap  <= MAX_GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_HIGH: cfg_q.min_high <= cfg_data;
				REG_MAX_HIGH: cfg_q.max_high <= cfg_data;
				REG_MIN_GAP:  cfg_q.min_gap  <= cfg_data;
				REG_MAX_GAP:  cfg_q.max_gap  <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar c = 0; c < NUM_WIDTHS; c++) begin : g_lane
		if (c < LANES) begin : g_on
			rcpw_lane u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.accept   (accept),
				.edge_hit (edge_mask[c]),
				.level    (pin_levels[c]),
				.now_us   (now_us),
				.cfg      (cfg_q),
				.lane_out (lanes[c])
			);
		end else begin : g_off
			assign lanes[c] = '0;
		end
	end

	rcpw_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.lanes    (lanes),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: rtl/rcpw_lane.sv
// One channel lane: edge timing state, window checks and stored pulse width.
`timescale 1ns / 1ps
module rcpw_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        edge_hit,
	input  logic                        level,
	input  logic [rcpw_pkg::STAMP_W-1:0] now_us,
	input  rcpw_pkg::rcpw_cfg_t         cfg,
	output rcpw_pkg::rcpw_lane_out_t    lane_out
);
	import rcpw_pkg::*;

	logic               armed_q;
	logic [STAMP_W-1:0] rise_q;
	logic [STAMP_W-1:0] fall_q;
	logic [WIDTH_W-1:0] width_q;

	logic [STAMP_W-1:0] gap;
	logic [STAMP_W-1:0] high;
	logic               gap_ok;
	logic               high_ok;
	logic               rise_ev;
	logic               fall_ev;
	logic               store;

	assign gap     = now_us - fall_q;
	assign high    = now_us - rise_q;
	assign gap_ok  = (gap >= {16'd0, cfg.min_gap}) && (gap <= {16'd0, cfg.max_gap});
	assign high_ok = (high >= {16'd0, cfg.min_high}) && (high <= {16'd0, cfg.max_high});
	assign rise_ev = accept && edge_hit && level;
	assign fall_ev = accept && edge_hit && !level;
	assign store   = fall_ev && armed_q && high_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			rise_q  <= '0;
			fall_q  <= '0;
			width_q <= '0;
		end else begin
			if (rise_ev) begin
				rise_q  <= now_us;
				armed_q <= gap_ok;
			end
			if (fall_ev) begin
				fall_q <= now_us;
			end
			if (store) begin
				width_q <= high[WIDTH_W-1:0];
				armed_q <= 1'b0;
			end
		end
	end

	always_comb begin
		lane_out.upd   = store;
		lane_out.width = store ? high[WIDTH_W-1:0] : width_q;
	end

endmodule

FILE: rtl/rcpw_merge.sv
// Merge stage: packs lane results into one item, output register with skid stage.
`timescale 1ns / 1ps
module rcpw_merge (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      push,
	input  rcpw_pkg::rcpw_lane_out_t [rcpw_pkg::NUM_WIDTHS-1:0] lanes,
	output logic                                      s_tready,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	output logic [rcpw_pkg::OUT_TDATA_W-1:0]          m_tdata
);
	import rcpw_pkg::*;

	logic [OUT_TDATA_W-1:0] packed_d;
	logic [OUT_TDATA_W-1:0] out_q;
	logic [OUT_TDATA_W-1:0] skid_q;
	logic                   out_valid_q;
	logic                   skid_valid_q;
	logic                   pop;
	logic [MASK_W-1:0]      upd_mask;

	always_comb begin
		packed_d = '0;
		for (int c = 0; c < NUM_WIDTHS; c++) begin
			packed_d[c*WIDTH_W +: WIDTH_W] = lanes[c].width;
			upd_mask[c] = lanes[c].upd;
		end
		packed_d[NUM_WIDTHS*WIDTH_W +: MASK_W] = upd_mask;
	end

	assign pop = out_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop && skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (pop || !out_valid_q) begin
				out_valid_q <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end else if ((pop || !out_valid_q) && push) begin
			out_q <= packed_d;
		end else if (push) begin
			skid_q <= packed_d;
		end
	end

	assign s_tready = !skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

FILE: rtl/rcpw_checker.sv
// Port-level checker for the RC pulse width capture block, bound to the top level.
`timescale 1ns / 1ps
module rcpw_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [rcpw_pkg::IN_TDATA_W-1:0]   s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [rcpw_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import rcpw_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output item changed");

	a_full_means_out: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled while output empty");

	a_empty_push: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> m_tvalid)
		else $error("accepted item produced no result");

	a_no_edge_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid && (s_tdata[MASK_W-1:0] == '0)
		|=> m_tdata[NUM_WIDTHS*WIDTH_W +: MASK_W] == '0)
		else $error("update flagged without an edge");

endmodule

bind rc_pulse_width_capture rcpw_checker u_rcpw_checker (.*);

FILE: bench/tb_rc_pulse_width_capture.sv
// Self-checking testbench for the RC pulse width capture block under random flow control.
`timescale 1ns / 1ps
module tb_rc_pulse_width_capture;
	import rcpw_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 4;
	localparam int ITEMS_PHASE   = 250;
	localparam int HOLD_CYCLES   = 160;
	localparam int MAX_PRINTS    = 40;
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 8'd9;

	typedef struct packed {
		logic [STAMP_W-1:0] now_us;
		logic [MASK_W-1:0]  pin_levels;
		logic [MASK_W-1:0]  edge_mask;
	} rc_event_t;

	typedef struct packed {
		logic [MASK_W-1:0]                    updated;
		logic [NUM_WIDTHS-1:0][WIDTH_W-1:0]   width;
	} rc_result_t;

	typedef struct {
		rc_event_t  ev;
		logic       pinned;
		rc_result_t want;
	} rc_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic row_pinned = 1'b0;
	rc_result_t row_pinned_result = '0;

	rc_pulse_width_capture u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [WIDTH_W-1:0] win_min_high = MIN_HIGH_RST;
	logic [WIDTH_W-1:0] win_max_high = MAX_HIGH_RST;
	logic [WIDTH_W-1:0] win_min_gap  = MIN_GAP_RST;
	logic [WIDTH_W-1:0] win_max_gap  = MAX_GAP_RST;
	logic               ch_armed   [NUM_WIDTHS] = '{default: 1'b0};
	logic [STAMP_W-1:0] ch_rise_at [NUM_WIDTHS] = '{default: '0};
	logic [STAMP_W-1:0] ch_fall_at [NUM_WIDTHS] = '{default: '0};
	logic [WIDTH_W-1:0] ch_width   [NUM_WIDTHS] = '{default: '0};

	// stimulus-side view of the windows and of each channel's last edge
	logic [WIDTH_W-1:0] gen_min_high = MIN_HIGH_RST;
	logic [WIDTH_W-1:0] gen_max_high = MAX_HIGH_RST;
	logic [WIDTH_W-1:0] gen_min_gap  = MIN_GAP_RST;
	logic [WIDTH_W-1:0] gen_max_gap  = MAX_GAP_RST;
	logic               gen_level [NUM_WIDTHS] = '{default: 1'b0};
	logic [STAMP_W-1:0] gen_stamp [NUM_WIDTHS] = '{default: '0};

	rc_result_t pending_widths[$];
	rc_row_t    dir_rows[$];
	string      width_name[NUM_WIDTHS] = '{"width_roll", "width_pitch", "width_yaw",
		"width_throttle"};

	int unsigned cycle_count = 0;
	int          mismatches = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          widths_stored = 0;
	int          window_settings = 1;
	int          tx_streak = 0;

	int          rx_taken = 0;
	int          hold_left = 0;
	int          hold_mark = -1;
	int          rx_stall = 0;
	int          rx_streak = 0;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
	endtask

	function automatic logic in_window(input logic [STAMP_W-1:0] t,
		input logic [WIDTH_W-1:0] lo, input logic [WIDTH_W-1:0] hi);
		return t >= STAMP_W'(lo) && t <= STAMP_W'(hi);
	endfunction

	function automatic rc_result_t capture_widths(input rc_event_t ev);
		rc_result_t r;
		logic [STAMP_W-1:0] span;
		r = '0;
		for (int c = 0; c < NUM_WIDTHS; c++) begin
			if (ev.edge_mask[c]) begin
				if (ev.pin_levels[c]) begin
					span = ev.now_us - ch_fall_at[c];
					ch_rise_at[c] = ev.now_us;
					ch_armed[c] = in_window(span, win_min_gap, win_max_gap);
				end else begin
					span = ev.now_us - ch_rise_at[c];
					ch_fall_at[c] = ev.now_us;
					if (ch_armed[c] && in_window(span, win_min_high, win_max_high)) begin
						ch_width[c] = span[WIDTH_W-1:0];
						ch_armed[c] = 1'b0;
						r.updated[c] = 1'b1;
						widths_stored++;
					end
				end
			end
		end
		for (int c = 0; c < NUM_WIDTHS; c++)
			r.width[c] = ch_width[c];
		return r;
	endfunction

	always @(posedge clk) begin
		rc_result_t got;
		rc_result_t want;
		rc_result_t calc;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MIN_HIGH: win_min_high = cfg_data;
					REG_MAX_HIGH: win_max_high = cfg_data;
					REG_MIN_GAP:  win_min_gap  = cfg_data;
					REG_MAX_GAP:  win_max_gap  = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				calc = capture_widths(rc_event_t'(s_tdata));
				pending_widths.push_back(row_pinned ? row_pinned_result : calc);
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				got = rc_result_t'(m_tdata[OUT_PAYLOAD_W-1:0]);
				if (pending_widths.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with none outstanding",
						results_seen));
				end else begin
					want = pending_widths.pop_front();
					for (int i = 0; i < NUM_WIDTHS; i++)
						if (got.width[i] !== want.width[i])
							report_mismatch($sformatf("result %0d %s got %0d expected %0d",
								results_seen, width_name[i], got.width[i], want.width[i]));
					if (got.updated !== want.updated)
						report_mismatch($sformatf("result %0d updated_mask got %b expected %b",
							results_seen, got.updated, want.updated));
				end
			end
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(99, 0);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	always @(posedge clk) begin
		logic rdy_next;
		rdy_next = 1'b0;
		if (arst_n) begin
			if (m_tvalid && m_tready)
				rx_taken++;
			if (hold_left != 0) begin
				hold_left--;
			end else if ((rx_taken == 450 || rx_taken == 1337) && hold_mark != rx_taken) begin
				hold_mark = rx_taken;
				hold_left = HOLD_CYCLES - 1;
			end else if (rx_stall != 0) begin
				rx_stall--;
			end else begin
				rdy_next = 1'b1;
				if (rx_streak != 0)
					rx_streak--;
				else if ($urandom_range(99, 0) < 30)
					rx_stall = idle_len();
				if (rx_streak == 0 && $urandom_range(99, 0) < 3)
					rx_streak = $urandom_range(150, 50);
			end
		end
		m_tready <= rdy_next;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items sent, %0d results seen",
				cycle_count, items_sent, results_seen);
			$display("rc_pulse_width_capture verification failed");
			$finish;
		end
	end

	task automatic send_event(input rc_event_t ev, input logic pinned, input rc_result_t want);
		int gap;
		if (tx_streak != 0) begin
			tx_streak--;
			gap = 0;
		end else begin
			gap = idle_len();
			if ($urandom_range(99, 0) < 3)
				tx_streak = $urandom_range(120, 40);
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ev;
		row_pinned <= pinned;
		row_pinned_result <= want;
		for (int c = 0; c < NUM_WIDTHS; c++) begin
			if (ev.edge_mask[c]) begin
				gen_level[c] = ev.pin_levels[c];
				gen_stamp[c] = ev.now_us;
			end
		end
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic add_row(input logic [MASK_W-1:0] mask, input logic [MASK_W-1:0] lvl,
		input logic [STAMP_W-1:0] now, input logic pinned, input logic [WIDTH_W-1:0] w,
		input logic [MASK_W-1:0] upd);
		rc_row_t row;
		row.ev.edge_mask = mask;
		row.ev.pin_levels = lvl;
		row.ev.now_us = now;
		row.pinned = pinned;
		row.want.width = {NUM_WIDTHS{w}};
		row.want.updated = upd;
		dir_rows.push_back(row);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		row_pinned <= 1'b0;
		while (results_seen != items_sent) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_windows(input logic [WIDTH_W-1:0] min_h, input logic [WIDTH_W-1:0] max_h,
		input logic [WIDTH_W-1:0] min_g, input logic [WIDTH_W-1:0] max_g);
		write_reg(REG_MIN_HIGH, min_h);
		write_reg(REG_MAX_HIGH, max_h);
		write_reg(REG_MIN_GAP, min_g);
		write_reg(REG_MAX_GAP, max_g);
		cfg_valid <= 1'b0;
		gen_min_high = min_h;
		gen_max_high = max_h;
		gen_min_gap = min_g;
		gen_max_gap = max_g;
		window_settings++;
		@(posedge clk);
	endtask

	function automatic logic [STAMP_W-1:0] pick_span(input logic [WIDTH_W-1:0] lo,
		input logic [WIDTH_W-1:0] hi);
		int r;
		r = $urandom_range(99, 0);
		if (r < 45 && lo <= hi)
			return $urandom_range(32'(hi), 32'(lo));
		if (r < 70)
			return 32'(lo) + $urandom_range(4, 0) - 32'd2;
		if (r < 90)
			return 32'(hi) + $urandom_range(4, 0) - 32'd2;
		return $urandom;
	endfunction

	task automatic run_random(input int count);
		rc_event_t ev;
		int done;
		int lead;
		logic rising;
		logic [STAMP_W-1:0] span;
		done = 0;
		while (done < count) begin
			if ($urandom_range(99, 0) < 4) begin
				ev.edge_mask = MASK_W'($urandom);
				ev.pin_levels = MASK_W'($urandom);
				ev.now_us = $urandom;
			end else begin
				lead = $urandom_range(NUM_WIDTHS - 1, 0);
				rising = !gen_level[lead];
				if ($urandom_range(99, 0) < 8)
					rising = !rising;
				span = rising ? pick_span(gen_min_gap, gen_max_gap)
					: pick_span(gen_min_high, gen_max_high);
				ev.now_us = gen_stamp[lead] + span;
				ev.edge_mask = MASK_W'(1 << lead);
				if ($urandom_range(99, 0) < 25)
					ev.edge_mask |= MASK_W'($urandom);
				ev.pin_levels = MASK_W'($urandom);
				ev.pin_levels[lead] = rising;
			end
			if (ev.edge_mask != '0)
				done++;
			send_event(ev, 1'b0, '0);
		end
	endtask

	initial begin
		logic [WIDTH_W-1:0] lo_h;
		logic [WIDTH_W-1:0] lo_g;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(4'hF, 4'h0, 32'd0,     1'b1, 16'd0,    4'h0);
		add_row(4'hF, 4'hF, 32'd12000, 1'b1, 16'd0,    4'h0);
		add_row(4'hF, 4'h0, 32'd12950, 1'b1, 16'd950,  4'hF);
		add_row(4'hF, 4'hF, 32'd36950, 1'b1, 16'd950,  4'h0);
		add_row(4'hF, 4'h0, 32'd39025, 1'b1, 16'd2075, 4'hF);
		add_row(4'hF, 4'hF, 32'd51024, 1'b1, 16'd2075, 4'h0);
		add_row(4'hF, 4'h0, 32'd52024, 1'b1, 16'd2075, 4'h0);
		add_row(4'hF, 4'hF, 32'd76025, 1'b1, 16'd2075, 4'h0);
		add_row(4'hF, 4'h0, 32'd77525, 1'b1, 16'd2075, 4'h0);
		add_row(4'hF, 4'hF, 32'd92525, 1'b1, 16'd2075, 4'h0);
		add_row(4'hF, 4'h0, 32'd93474, 1'b1, 16'd2075, 4'h0);
		add_row(4'hF, 4'h0, 32'd94601, 1'b1, 16'd2075, 4'h0);
		add_row(4'hF, 4'h0, 32'd93725, 1'b1, 16'd1200, 4'hF);
		add_row(4'h0, 4'hF, 32'hFFFF_FFFF, 1'b1, 16'd1200, 4'h0);
		add_row(4'hF, 4'h0, 32'hFFFF_FF00, 1'b1, 16'd1200, 4'h0);
		add_row(4'hF, 4'hF, 32'h0000_3998, 1'b1, 16'd1200, 4'h0);
		add_row(4'hF, 4'h0, 32'h0000_3F74, 1'b1, 16'd1500, 4'hF);
		add_row(4'b0101, 4'b0001, 32'd29244, 1'b0, 16'd0, 4'h0);
		add_row(4'b1111, 4'b0100, 32'd31044, 1'b0, 16'd0, 4'h0);
		add_row(4'b1010, 4'b1010, 32'd51044, 1'b0, 16'd0, 4'h0);
		add_row(4'b1010, 4'b0000, 32'd53044, 1'b0, 16'd0, 4'h0);
		add_row(4'b0000, 4'b1111, 32'h5555_5555, 1'b0, 16'd0, 4'h0);
		add_row(4'b1111, 4'b1111, 32'hAAAA_AAAA, 1'b0, 16'd0, 4'h0);
		foreach (dir_rows[i])
			send_event(dir_rows[i].ev, dir_rows[i].pinned, dir_rows[i].want);
		drain();

		run_random(ITEMS_PHASE);
		drain();
		set_windows(16'd0, 16'd65535, 16'd0, 16'd65535);
		run_random(ITEMS_PHASE);
		drain();
		set_windows(16'd2000, 16'd1000, 16'd30000, 16'd100);
		write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
		run_random(ITEMS_PHASE);
		drain();
		set_windows(16'd1500, 16'd1500, 16'd20000, 16'd20000);
		run_random(ITEMS_PHASE);
		drain();
		lo_h = WIDTH_W'($urandom_range(3000, 0));
		lo_g = WIDTH_W'($urandom_range(40000, 0));
		set_windows(lo_h, lo_h + WIDTH_W'($urandom_range(3000, 0)),
			lo_g, lo_g + WIDTH_W'($urandom_range(20000, 0)));
		run_random(ITEMS_PHASE);
		drain();
		set_windows(16'd65535, 16'd65535, 16'd65535, 16'd65535);
		run_random(ITEMS_PHASE);
		drain();
		set_windows(MIN_HIGH_RST, MAX_HIGH_RST, MIN_GAP_RST, MAX_GAP_RST);
		run_random(ITEMS_PHASE);
		drain();
		repeat (8) @(posedge clk);

		if (pending_widths.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_widths.size()));
		$display("covered %0d edge items over %0d window settings, %0d pulse widths stored",
			items_sent, window_settings, widths_stored);
		$display("%0d results compared, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("rc_pulse_width_capture verification clean");
		else
			$display("rc_pulse_width_capture verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/rcpw_pkg.sv
rtl/rcpw_lane.sv
rtl/rcpw_merge.sv
rtl/rc_pulse_width_capture.sv
rtl/rcpw_checker.sv
bench/tb_rc_pulse_width_capture.sv
